// ===== src/onb_pkg.sv =====
// Shared types and constants for the Oren-Nayar diffuse evaluator.
// Used by onb_geom, onb_div, onb_scale and oren_nayar_brdf_eval; no dependencies.
package onb_pkg;

  localparam int NUM_SAMP     = 4;
  localparam int DIR_W        = 16;
  localparam int Q16_W        = 16;
  localparam int HSQ_W        = 32;
  localparam int T_W          = 32;
  localparam int BRK_W        = 48;
  localparam int DVD_W        = 63;
  localparam int QUOT_W       = 48;
  localparam int DIV_STEP     = 4;
  localparam int DIV_STAGES   = QUOT_W / DIV_STEP;
  localparam int GEOM_STAGES  = 6;
  localparam int SCALE_STAGES = 3;
  localparam int PIPE_DEPTH   = GEOM_STAGES + DIV_STAGES + SCALE_STAGES;
  localparam int OCC_W        = $clog2(PIPE_DEPTH + 1);
  localparam int WPROD_W      = 63;
  localparam int W_W          = 33;
  localparam int CPROD_W      = Q16_W + W_W;

  // horizontal magnitude squared threshold in Q2.30 (1e-8)
  localparam logic [HSQ_W-1:0] HSQ_CUTOFF = 32'd10;
  // 1/pi in Q0.32
  localparam logic [30:0]      INV_PI_Q32 = 31'd1367130551;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 2'd1;

  typedef logic [Q16_W-1:0] q016_t;
  typedef logic [NUM_SAMP-1:0][Q16_W-1:0] refl_vec_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] xo;
    logic signed [DIR_W-1:0] yo;
    logic signed [DIR_W-1:0] zo;
    logic signed [DIR_W-1:0] xi;
    logic signed [DIR_W-1:0] yi;
    logic signed [DIR_W-1:0] zi;
  } dir_set_t;

  typedef struct packed {
    logic [DVD_W-1:0] dividend;
    logic [DIR_W-1:0] divisor;
    logic             w_zero;
    refl_vec_t        refl;
  } div_in_t;

  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic              w_zero;
    refl_vec_t         refl;
  } div_out_t;

endpackage

// ===== src/onb_geom.sv =====
// Front stages: direction products, coupling term, bracket and the dividend |zo|*bracket.
// Depends on onb_pkg.
module onb_geom (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  onb_pkg::dir_set_t  in_dir,
  input  onb_pkg::refl_vec_t in_refl,
  input  onb_pkg::q016_t     coef_a,
  input  onb_pkg::q016_t     coef_b,
  output logic               out_valid,
  input  logic               out_stall,
  output onb_pkg::div_in_t   out_data
);
  import onb_pkg::*;

  logic [GEOM_STAGES-1:0] v_r;
  logic [GEOM_STAGES:0]   ce;
  refl_vec_t              refl_r [GEOM_STAGES-1];

  // stage 1
  logic signed [31:0] sq_xo, sq_yo, sq_xi, sq_yi, p_x, p_y;
  logic [HSQ_W-1:0]   hsq_o_r, hsq_o_nxt, hsq_i_r, hsq_i_nxt;
  logic signed [32:0] dot_r, dot_nxt;
  logic [DIR_W-1:0]   az1_r, az1_nxt, bz1_r, bz1_nxt;
  // stage 2
  logic [T_W-1:0]     t_r, t_nxt;
  logic [DIR_W-1:0]   m2_r, m2_nxt, az2_r;
  // stage 3
  logic [31:0]        am_full;
  logic [30:0]        am_r;
  logic [BRK_W-1:0]   bt_r, bt_nxt;
  logic [DIR_W-1:0]   m3_r, az3_r;
  // stage 4
  logic [BRK_W-1:0]   brk_r, brk_nxt;
  logic [DIR_W-1:0]   m4_r, az4_r;
  // stage 5
  logic [39:0]        pp_lo_r, pp_lo_nxt, pp_hi_r, pp_hi_nxt;
  logic [DIR_W-1:0]   m5_r;
  logic               wz5_r;
  // stage 6
  logic [63:0]        dvd_sum;
  div_in_t            out_r;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    ce[GEOM_STAGES] = !out_stall;
    for (int k = GEOM_STAGES - 1; k >= 0; k--) begin
      ce[k] = !v_r[k] || ce[k+1];
    end
  end

  assign in_stall  = !ce[0];
  assign out_valid = v_r[GEOM_STAGES-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < GEOM_STAGES; k++) begin
        if (ce[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    sq_xo = in_dir.xo * in_dir.xo;
    sq_yo = in_dir.yo * in_dir.yo;
    sq_xi = in_dir.xi * in_dir.xi;
    sq_yi = in_dir.yi * in_dir.yi;
    p_x   = in_dir.xi * in_dir.xo;
    p_y   = in_dir.yi * in_dir.yo;
    hsq_o_nxt = sq_xo + sq_yo;
    hsq_i_nxt = sq_xi + sq_yi;
    dot_nxt   = $signed({p_x[31], p_x}) + $signed({p_y[31], p_y});
    az1_nxt   = in_dir.zo[DIR_W-1] ? (~in_dir.zo + 16'd1) : in_dir.zo;
    bz1_nxt   = in_dir.zi[DIR_W-1] ? (~in_dir.zi + 16'd1) : in_dir.zi;
  end

  always_comb begin
    if (hsq_o_r > HSQ_CUTOFF && hsq_i_r > HSQ_CUTOFF && !dot_r[32] && dot_r != '0) begin
      t_nxt = dot_r[T_W-1:0];
    end else begin
      t_nxt = '0;
    end
    m2_nxt = (az1_r > bz1_r) ? az1_r : bz1_r;
  end

  assign am_full   = coef_a * m2_r;
  assign bt_nxt    = coef_b * t_r;
  assign brk_nxt   = {2'b00, am_r, 15'b0} + bt_r;
  assign pp_lo_nxt = az4_r * brk_r[23:0];
  assign pp_hi_nxt = az4_r * brk_r[BRK_W-1:24];
  assign dvd_sum   = {24'b0, pp_lo_r} + {pp_hi_r, 24'b0};

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      hsq_o_r   <= hsq_o_nxt;
      hsq_i_r   <= hsq_i_nxt;
      dot_r     <= dot_nxt;
      az1_r     <= az1_nxt;
      bz1_r     <= bz1_nxt;
      refl_r[0] <= in_refl;
    end
    if (ce[1]) begin
      t_r       <= t_nxt;
      m2_r      <= m2_nxt;
      az2_r     <= az1_r;
      refl_r[1] <= refl_r[0];
    end
    if (ce[2]) begin
      am_r      <= am_full[30:0];
      bt_r      <= bt_nxt;
      m3_r      <= m2_r;
      az3_r     <= az2_r;
      refl_r[2] <= refl_r[1];
    end
    if (ce[3]) begin
      brk_r     <= brk_nxt;
      m4_r      <= m3_r;
      az4_r     <= az3_r;
      refl_r[3] <= refl_r[2];
    end
    if (ce[4]) begin
      pp_lo_r   <= pp_lo_nxt;
      pp_hi_r   <= pp_hi_nxt;
      m5_r      <= m4_r;
      wz5_r     <= (az4_r == '0);
      refl_r[4] <= refl_r[3];
    end
    if (ce[5]) begin
      out_r.dividend <= dvd_sum[DVD_W-1:0];
      out_r.divisor  <= m5_r;
      out_r.w_zero   <= wz5_r;
      out_r.refl     <= refl_r[4];
    end
  end

endmodule

// ===== src/onb_div.sv =====
// Pipelined restoring divider: dividend / max(|zi|,|zo|), four quotient bits per stage.
// Depends on onb_pkg.
module onb_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  onb_pkg::div_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output onb_pkg::div_out_t out_data
);
  import onb_pkg::*;

  typedef struct packed {
    logic [DIR_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
    logic [QUOT_W-1:0] dvd_lo;
    logic [DIR_W-1:0]  divisor;
    logic              w_zero;
    refl_vec_t         refl;
  } div_pipe_t;

  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES:0]   ce;
  div_pipe_t             stg_r   [DIV_STAGES];
  div_pipe_t             stg_nxt [DIV_STAGES];
  div_pipe_t             init;

  always_comb begin
    ce[DIV_STAGES] = !out_stall;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      ce[k] = !v_r[k] || ce[k+1];
    end
  end

  assign in_stall = !ce[0];

  // dividend < divisor * 2^48, so its top bits already sit below the divisor
  always_comb begin
    init.rem     = {1'b0, in_data.dividend[DVD_W-1:QUOT_W]};
    init.quot    = '0;
    init.dvd_lo  = in_data.dividend[QUOT_W-1:0];
    init.divisor = in_data.divisor;
    init.w_zero  = in_data.w_zero;
    init.refl    = in_data.refl;
  end

  always_comb begin
    div_pipe_t   src;
    logic [16:0] trial;
    int          idx;
    for (int s = 0; s < DIV_STAGES; s++) begin
      src = (s == 0) ? init : stg_r[s-1];
      for (int j = 0; j < DIV_STEP; j++) begin
        idx   = QUOT_W - 1 - (s * DIV_STEP + j);
        trial = {src.rem, src.dvd_lo[idx]};
        if (trial >= {1'b0, src.divisor}) begin
          src.rem       = 16'(trial - {1'b0, src.divisor});
          src.quot[idx] = 1'b1;
        end else begin
          src.rem = trial[DIR_W-1:0];
        end
      end
      stg_nxt[s] = src;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (ce[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (ce[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_valid       = v_r[DIV_STAGES-1];
  assign out_data.quot   = stg_r[DIV_STAGES-1].quot;
  assign out_data.w_zero = stg_r[DIV_STAGES-1].w_zero;
  assign out_data.refl   = stg_r[DIV_STAGES-1].refl;

endmodule

// ===== src/onb_scale.sv =====
// Back stages: weight = quotient * 1/pi, per-sample scaling, rounding and saturation.
// Depends on onb_pkg; the last stage is the output register.
module onb_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  onb_pkg::div_out_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output onb_pkg::refl_vec_t out_contrib
);
  import onb_pkg::*;

  logic [SCALE_STAGES-1:0] v_r;
  logic [SCALE_STAGES:0]   ce;

  logic [WPROD_W-1:0]                 wprod_r, wprod_nxt;
  logic                               wz_r;
  refl_vec_t                          refl_r;
  logic [W_W-1:0]                     w;
  logic [NUM_SAMP-1:0][CPROD_W-1:0]   cprod_r, cprod_nxt;
  refl_vec_t                          contrib_r, contrib_nxt;

  always_comb begin
    ce[SCALE_STAGES] = !out_stall;
    for (int k = SCALE_STAGES - 1; k >= 0; k--) begin
      ce[k] = !v_r[k] || ce[k+1];
    end
  end

  assign in_stall = !ce[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < SCALE_STAGES; k++) begin
        if (ce[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
        end
      end
    end
  end

  assign wprod_nxt = in_data.quot[QUOT_W-1:16] * INV_PI_Q32;
  assign w         = wz_r ? '0 : wprod_r[WPROD_W-1:30];

  always_comb begin
    logic [CPROD_W:0] rnd;
    for (int k = 0; k < NUM_SAMP; k++) begin
      cprod_nxt[k] = refl_r[k] * w;
    end
    for (int k = 0; k < NUM_SAMP; k++) begin
      rnd = {1'b0, cprod_r[k]} + 50'h0_0000_8000_0000;
      contrib_nxt[k] = (rnd[CPROD_W:32] > 18'h0FFFF) ? 16'hFFFF : rnd[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      wprod_r <= wprod_nxt;
      wz_r    <= in_data.w_zero;
      refl_r  <= in_data.refl;
    end
    if (ce[1]) begin
      cprod_r <= cprod_nxt;
    end
    if (ce[2]) begin
      contrib_r <= contrib_nxt;
    end
  end

  assign out_valid   = v_r[SCALE_STAGES-1];
  assign out_contrib = contrib_r;

endmodule

// ===== src/oren_nayar_brdf_eval.sv =====
// Oren-Nayar diffuse term evaluator, top level: coefficient registers and pipeline wiring.
// Depends on onb_pkg, onb_geom, onb_div and onb_scale.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | sink      | in_valid/in_stall  | two directions (Q1.15), refl_0..3 (Q0.16)
//  out     | source    | out_valid/out_stall| contrib_0..3 (Q0.16, saturating)
//  cfg     | sink      | cfg_we             | cfg_index, cfg_wdata (coef_a, coef_b)
//
// One transaction per cycle sustained while out_stall is low; 6 front stages, 12 divider
// stages at four quotient bits each, 3 back stages ending in the output register.
// Synchronous active-low reset empties the pipeline and sets coef_a = 0xFFFF, coef_b = 0.
// A stall on the output only holds stages that are occupied; bubbles still close up,
// so input is taken while a result waits until every stage is full.
module oren_nayar_brdf_eval (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              in_out_dir_x,
  input  logic signed [15:0]              in_out_dir_y,
  input  logic signed [15:0]              in_out_dir_z,
  input  logic signed [15:0]              in_in_dir_x,
  input  logic signed [15:0]              in_in_dir_y,
  input  logic signed [15:0]              in_in_dir_z,
  input  logic [15:0]                     in_refl_0,
  input  logic [15:0]                     in_refl_1,
  input  logic [15:0]                     in_refl_2,
  input  logic [15:0]                     in_refl_3,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     out_contrib_0,
  output logic [15:0]                     out_contrib_1,
  output logic [15:0]                     out_contrib_2,
  output logic [15:0]                     out_contrib_3,
  input  logic                            cfg_we,
  input  logic [onb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_wdata
);
  import onb_pkg::*;

  q016_t     coef_a_r, coef_b_r;
  dir_set_t  dirs;
  refl_vec_t refl_in, contrib;
  div_in_t   geom_data;
  div_out_t  div_data;
  logic      geom_valid, geom_stall, div_valid, div_stall;
  logic      in_acc, out_acc;
  logic [OCC_W-1:0] occ_r, occ_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= 16'hFFFF;
      coef_b_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_A: coef_a_r <= cfg_wdata;
        CFG_COEF_B: coef_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign dirs.xo = in_out_dir_x;
  assign dirs.yo = in_out_dir_y;
  assign dirs.zo = in_out_dir_z;
  assign dirs.xi = in_in_dir_x;
  assign dirs.yi = in_in_dir_y;
  assign dirs.zi = in_in_dir_z;
  assign refl_in = {in_refl_3, in_refl_2, in_refl_1, in_refl_0};

  onb_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_dir    (dirs),
    .in_refl   (refl_in),
    .coef_a    (coef_a_r),
    .coef_b    (coef_b_r),
    .out_valid (geom_valid),
    .out_stall (geom_stall),
    .out_data  (geom_data)
  );

  onb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (geom_valid),
    .in_stall  (geom_stall),
    .in_data   (geom_data),
    .out_valid (div_valid),
    .out_stall (div_stall),
    .out_data  (div_data)
  );

  onb_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (div_valid),
    .in_stall    (div_stall),
    .in_data     (div_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_contrib (contrib)
  );

  assign out_contrib_0 = contrib[0];
  assign out_contrib_1 = contrib[1];
  assign out_contrib_2 = contrib[2];
  assign out_contrib_3 = contrib[3];

  // transactions in flight
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) begin
      occ_nxt = occ_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_stall_only_when_backed_up: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(PIPE_DEPTH))
    else $error("more transactions in flight than pipeline stages");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (occ_r != '0))
    else $error("result presented with nothing in flight");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == OCC_W'(PIPE_DEPTH) && out_stall) |-> in_stall)
    else $error("full pipeline took a transaction under stall");

  a_cfg_coef_a: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == CFG_COEF_A) |=> (coef_a_r == $past(cfg_wdata)))
    else $error("coef_a write lost");

endmodule
